// ===== rtl/hql_pkg.sv =====
// Package for the hierarchical quadrant locator: sizes, word types, opcodes,
// register indexes and the elaboration-time helpers for quadrant numbering.
// No dependencies.
package hql_pkg;

    localparam int TABLE_DEPTH = 2048;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);   // quadrant / entry width
    localparam int CNT_W       = ADDR_BITS + 1;         // counts up to TABLE_DEPTH
    localparam int MAX_DIMS    = 2;
    localparam int COORD_BITS  = 32;
    localparam int SPLIT_W     = MAX_DIMS * COORD_BITS; // one table entry
    localparam int CHILD_W     = CNT_W + MAX_DIMS;      // base + (off << D) + idx
    localparam int LEVEL_W     = 4;
    localparam int DIM_W       = 2;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    typedef enum logic
    {
        OP_WRITE  = 1'b0,
        OP_LOCATE = 1'b1
    } op_t;

    typedef enum logic
    {
        REG_DIM_COUNT   = 1'b0,
        REG_LEVEL_COUNT = 1'b1
    } reg_idx_t;

    localparam logic [DIM_W-1:0]   DIM_RESET   = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 4'd5;

    // Quadrants on levels 0..lv with 2^d children each, saturated at table depth.
    function automatic int cum_quads(input int d, input int lv);
        longint sum;
        longint term;
        sum  = 0;
        term = 1;
        for (int j = 0; j <= lv; j++)
        begin
            if (sum < TABLE_DEPTH)
            begin
                sum = sum + term;
            end
            if (term < TABLE_DEPTH)
            begin
                term = term << d;
            end
        end
        if (sum > TABLE_DEPTH)
        begin
            sum = TABLE_DEPTH;
        end
        return int'(sum);
    endfunction

    // Levels whose nodes may still have a child inside the table.
    function automatic int num_levels();
        int n;
        n = 0;
        for (int k = 0; k < 32; k++)
        begin
            if (cum_quads(1, k) < TABLE_DEPTH)
            begin
                n = k + 1;
            end
        end
        return n;
    endfunction

    localparam int NUM_LEVELS = num_levels();
    localparam int PIPE_LAT   = 2 * NUM_LEVELS + 1;

    // Span of entry numbers that can sit on level k for any dimension count.
    function automatic int lvl_lo(input int k);
        return (k == 0) ? 0 : cum_quads(1, k - 1);
    endfunction

    function automatic int lvl_hi(input int k);
        return cum_quads(MAX_DIMS, k);
    endfunction

    localparam int LIMIT_ENTRIES = 2 ** (LEVEL_W + 1);

    typedef logic [CNT_W-1:0] limit_tab_t [0:LIMIT_ENTRIES-1];

    // Quadrant count indexed by {two dims, level count}.
    function automatic limit_tab_t build_limits();
        limit_tab_t t;
        for (int i = 0; i < LIMIT_ENTRIES; i++)
        begin
            t[i] = CNT_W'(cum_quads((i >= 2 ** LEVEL_W) ? 2 : 1, i % (2 ** LEVEL_W)));
        end
        return t;
    endfunction

    localparam limit_tab_t LIMIT_TAB = build_limits();

    typedef struct packed
    {
        op_t                           op;
        logic                          done;
        logic [ADDR_BITS-1:0]          cur;   // entry number for writes
        logic [ADDR_BITS-1:0]          off;   // offset within the current level
        logic signed [COORD_BITS-1:0]  c0;
        logic signed [COORD_BITS-1:0]  c1;
    } item_t;

    typedef struct packed
    {
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] hi;
        logic [CNT_W-1:0] base1;
        logic [CNT_W-1:0] base2;
    } lvl_t;

    typedef struct packed
    {
        logic             d2;
        logic [CNT_W-1:0] limit;
    } cfg_t;

endpackage

// ===== rtl/hql_ram.sv =====
// Generic single-port RAM, registered read.
// No dependencies.
module hql_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 64
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:DEPTH-1];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/hql_level.sv =====
// One tree level of the locate pipeline: RAM access slot, then compare and
// child step. Depends on hql_pkg; its split-point RAM sits in the top level.
module hql_level (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hql_pkg::lvl_t                       lvl,
    input  hql_pkg::cfg_t                       cfg,
    input  logic                                in_vld,
    input  hql_pkg::item_t                      in_item,
    input  logic [hql_pkg::SPLIT_W-1:0]         rd_data,
    output logic [hql_pkg::ADDR_BITS-1:0]       mem_addr,
    output logic                                mem_we,
    output logic                                out_vld,
    output hql_pkg::item_t                      out_item
);

    import hql_pkg::*;

    logic                          mid_vld_reg;
    item_t                         mid_reg;
    logic                          out_vld_reg;
    item_t                         out_reg;
    item_t                         out_next;
    logic                          in_span;
    logic signed [COORD_BITS-1:0]  sp0;
    logic signed [COORD_BITS-1:0]  sp1;
    logic [MAX_DIMS-1:0]           idx;
    logic [CNT_W-1:0]              base;
    logic [ADDR_BITS+1:0]          step;
    logic [CHILD_W-1:0]            child;

    // Writes land in this level's RAM as they pass, keeping order with locates.
    assign in_span  = (CNT_W'(in_item.cur) >= lvl.lo) && (CNT_W'(in_item.cur) < lvl.hi);
    assign mem_we   = in_vld && (in_item.op == OP_WRITE) && in_span;
    assign mem_addr = in_item.cur - lvl.lo[ADDR_BITS-1:0];

    always_comb
    begin
        out_next = mid_reg;
        sp0      = rd_data[COORD_BITS-1:0];
        sp1      = rd_data[SPLIT_W-1:COORD_BITS];
        idx[0]   = (mid_reg.c0 >= sp0);
        idx[1]   = cfg.d2 && (mid_reg.c1 >= sp1);
        base     = cfg.d2 ? lvl.base2 : lvl.base1;
        step     = cfg.d2 ? {mid_reg.off, 2'b00} : {1'b0, mid_reg.off, 1'b0};
        step     = step | (ADDR_BITS+2)'(idx);
        child    = CHILD_W'(base) + CHILD_W'(step);
        if ((mid_reg.op == OP_LOCATE) && !mid_reg.done)
        begin
            if (child >= CHILD_W'(cfg.limit))
            begin
                out_next.done = 1'b1;
            end
            else
            begin
                out_next.cur = child[ADDR_BITS-1:0];
                out_next.off = step[ADDR_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            mid_vld_reg <= in_vld;
            out_vld_reg <= mid_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg <= in_item;
        out_reg <= out_next;
    end

    assign out_vld  = out_vld_reg;
    assign out_item = out_reg;

endmodule

// ===== rtl/hierarchical_quadrant_locator.sv =====
// Top level of the hierarchical quadrant locator: command port, APB register
// file and one pipeline level with its own split-point RAM per tree level.
// Depends on hql_pkg, hql_level and hql_ram.
//
//  channel   | handshake                          | word
//  ----------+------------------------------------+-----------------------------------
//  command   | start, busy (taken: start & !busy) | opcode, entry_index, coord_0/1
//  result    | strobe, one cycle, cannot stall    | quadrant
//  registers | APB psel/penable/pwrite, pready=1  | paddr, pwdata, prdata
//
//  A word enters every cycle; busy stays low. A locate word passes one input
//  register, then per level (11 levels for a 2048-entry table) a register for
//  the RAM read slot and one for compare and child step. Write words travel
//  the same path and update each level's RAM in passing, so results follow
//  command order. Reset clears the valid bits and registers only; RAM contents
//  are undefined until written and need no clearing pass.
module hierarchical_quadrant_locator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 opcode,
    input  logic [hql_pkg::ADDR_BITS-1:0]        entry_index,
    input  logic signed [hql_pkg::COORD_BITS-1:0] coord_0,
    input  logic signed [hql_pkg::COORD_BITS-1:0] coord_1,
    output logic                                 strobe,
    output logic [hql_pkg::ADDR_BITS-1:0]        quadrant,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [hql_pkg::PADDR_W-1:0]          paddr,
    input  logic [hql_pkg::PDATA_W-1:0]          pwdata,
    output logic [hql_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready
);

    import hql_pkg::*;

    logic [DIM_W-1:0]    dim_count_reg;
    logic [LEVEL_W-1:0]  level_count_reg;
    logic [CNT_W-1:0]    limit_reg;
    logic                reg_wr;
    reg_idx_t            reg_sel;
    cfg_t                cfg;

    logic                entry_vld_reg;
    item_t               entry_reg;
    item_t               entry_next;

    logic [NUM_LEVELS:0] stg_vld;
    item_t               stg_item [0:NUM_LEVELS];

    // ---------------------------------------------------------------- registers
    // Dim count 0 behaves as 1 and 3 as 2, so bit 1 alone picks four children.
    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[2]);
    assign reg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_count_reg   <= DIM_RESET;
            level_count_reg <= LEVEL_RESET;
            limit_reg       <= LIMIT_TAB[{DIM_RESET[1], LEVEL_RESET}];
        end
        else
        begin
            if (reg_wr)
            begin
                case (reg_sel)
                    REG_DIM_COUNT:   dim_count_reg   <= pwdata[DIM_W-1:0];
                    REG_LEVEL_COUNT: level_count_reg <= pwdata[LEVEL_W-1:0];
                    default:         ;
                endcase
            end
            // Quadrant count, capped at the table depth; registered from the dim and level
            // count registers after they take a write.
            limit_reg <= LIMIT_TAB[{dim_count_reg[1], level_count_reg}];
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_DIM_COUNT:   prdata = PDATA_W'(dim_count_reg);
            REG_LEVEL_COUNT: prdata = PDATA_W'(level_count_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.d2    = dim_count_reg[1];
    assign cfg.limit = limit_reg;

    // ---------------------------------------------------------------- command in
    // The pipeline never stalls, so a word is taken whenever start is high.
    assign busy = 1'b0;

    always_comb
    begin
        entry_next.op   = op_t'(opcode);
        entry_next.done = 1'b0;
        entry_next.cur  = (op_t'(opcode) == OP_WRITE) ? entry_index : '0;
        entry_next.off  = '0;
        entry_next.c0   = coord_0;
        entry_next.c1   = coord_1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_vld_reg <= 1'b0;
        end
        else
        begin
            entry_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign stg_vld[0]  = entry_vld_reg;
    assign stg_item[0] = entry_reg;

    // ---------------------------------------------------------------- levels
    // Level k's RAM holds only the entries that can lie on level k for either
    // dimension count; quadrant 0 at the root, children numbered level by level.
    for (genvar k = 0; k < NUM_LEVELS; k++)
    begin : g_lvl
        localparam int   LO    = lvl_lo(k);
        localparam int   HI    = lvl_hi(k);
        localparam int   DEPTH = HI - LO;
        localparam int   AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
        localparam lvl_t LV    = '{lo:    CNT_W'(LO),
                                   hi:    CNT_W'(HI),
                                   base1: CNT_W'(cum_quads(1, k)),
                                   base2: CNT_W'(cum_quads(2, k))};

        logic [ADDR_BITS-1:0] addr;
        logic                 we;
        logic [SPLIT_W-1:0]   rdata;

        hql_level u_level (
            .clk      (clk),
            .rst_n    (rst_n),
            .lvl      (LV),
            .cfg      (cfg),
            .in_vld   (stg_vld[k]),
            .in_item  (stg_item[k]),
            .rd_data  (rdata),
            .mem_addr (addr),
            .mem_we   (we),
            .out_vld  (stg_vld[k+1]),
            .out_item (stg_item[k+1])
        );

        hql_ram #(
            .DEPTH  (DEPTH),
            .ADDR_W (AW),
            .DATA_W (SPLIT_W)
        ) u_ram (
            .clk   (clk),
            .we    (we),
            .addr  (addr[AW-1:0]),
            .wdata ({stg_item[k].c1, stg_item[k].c0}),
            .rdata (rdata)
        );
    end

    // ---------------------------------------------------------------- result out
    assign strobe   = stg_vld[NUM_LEVELS] && (stg_item[NUM_LEVELS].op == OP_LOCATE);
    assign quadrant = stg_item[NUM_LEVELS].cur;

endmodule

// ===== rtl/hql_checker.sv =====
// Port-level checks for the hierarchical quadrant locator, bound to the top.
// Depends on hql_pkg and hierarchical_quadrant_locator.
module hql_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 opcode,
    input logic                                 strobe,
    input logic                                 psel,
    input logic                                 penable,
    input logic                                 pwrite,
    input logic [hql_pkg::PADDR_W-1:0]          paddr,
    input logic [hql_pkg::PDATA_W-1:0]          pwdata,
    input logic [hql_pkg::PDATA_W-1:0]          prdata
);

    import hql_pkg::*;

    // Every result word comes from a locate taken a fixed latency earlier.
    a_result_has_locate: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(start && !busy && opcode, PIPE_LAT))
        else $error("result word without a matching locate");

    // Every locate taken yields its result word after the fixed latency.
    a_locate_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode) |-> ##PIPE_LAT strobe)
        else $error("locate word lost");

    // A dim count write reads back on an immediate read of the same register.
    a_dim_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr[2] == REG_DIM_COUNT)) |=>
        (!(psel && !pwrite && (paddr[2] == REG_DIM_COUNT))
         || (prdata[DIM_W-1:0] == $past(pwdata[DIM_W-1:0]))))
        else $error("dim count read-back mismatch");

endmodule

bind hierarchical_quadrant_locator hql_checker u_hql_checker (.*);

// ===== tb/sv/hierarchical_quadrant_locator_tb.sv =====
// Self-checking testbench for the hierarchical quadrant locator: directed table, then
// phased random words with on-demand table filling and a predictor of the tree descent.
// Depends on hql_pkg and the hierarchical_quadrant_locator RTL.
module hierarchical_quadrant_locator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hql_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 200;            // command words per phase, fills included
    localparam int SETTLE       = PIPE_LAT + 4;   // write words leave no result behind

    localparam logic signed [COORD_BITS-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_BITS-1:0] C_MIN = 32'sh8000_0000;

    typedef enum { ROW_WORD, ROW_REG } row_kind_t;

    // One line of the directed table: a register write or a command word.
    typedef struct {
        row_kind_t                    kind;
        reg_idx_t                     rsel;
        logic [PDATA_W-1:0]           value;
        op_t                          op;
        logic [ADDR_BITS-1:0]         entry;
        logic signed [COORD_BITS-1:0] c0;
        logic signed [COORD_BITS-1:0] c1;
        bit                           typed;  // quad below is the hand-worked answer
        logic [ADDR_BITS-1:0]         quad;
    } stim_row_t;

    // ------------------------------------------------------------------
    // DUT signals, all driven to known values from time zero
    // ------------------------------------------------------------------
    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          start       = 1'b0;
    logic                          busy;
    logic                          opcode      = 1'b0;
    logic [ADDR_BITS-1:0]          entry_index = '0;
    logic signed [COORD_BITS-1:0]  coord_0     = '0;
    logic signed [COORD_BITS-1:0]  coord_1     = '0;
    logic                          strobe;
    logic [ADDR_BITS-1:0]          quadrant;
    logic                          psel        = 1'b0;
    logic                          penable     = 1'b0;
    logic                          pwrite      = 1'b0;
    logic [PADDR_W-1:0]            paddr       = '0;
    logic [PDATA_W-1:0]            pwdata      = '0;
    logic [PDATA_W-1:0]            prdata;
    logic                          pready;

    // ------------------------------------------------------------------
    // Testbench copy of the block's state
    // ------------------------------------------------------------------
    logic signed [COORD_BITS-1:0]  split_x [TABLE_DEPTH];
    logic signed [COORD_BITS-1:0]  split_y [TABLE_DEPTH];
    bit                            split_written [TABLE_DEPTH];
    int                            written_list [$];   // entries holding a split point
    logic [DIM_W-1:0]              dim_reg   = DIM_RESET;
    logic [LEVEL_W-1:0]            level_reg = LEVEL_RESET;

    logic [ADDR_BITS-1:0]          quadrant_due [$];   // results still to come, oldest first

    int  n_words      = 0;
    int  n_locates    = 0;
    int  n_tab_writes = 0;
    int  n_settings   = 0;
    int  n_checked    = 0;
    int  n_faults     = 0;
    int  cycle_count  = 0;
    bit  gaps_on      = 1'b1;

    stim_row_t stim_rows [$];

    hierarchical_quadrant_locator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .entry_index (entry_index),
        .coord_0     (coord_0),
        .coord_1     (coord_1),
        .strobe      (strobe),
        .quadrant    (quadrant),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5ns clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Quadrants on levels 0..lv with 2^d children per node, unsaturated.
    function automatic longint quads_through(input int d, input int lv);
        longint sum;
        longint term;
        sum  = 0;
        term = 1;
        for (int j = 0; j <= lv; j++)
        begin
            sum  = sum + term;
            term = term << d;
        end
        return sum;
    endfunction

    // Walks the tree for a query point. Returns the first entry on the path that
    // holds no split point yet, or -1 with leaf set to the finest quadrant.
    function automatic int trace_descent(input logic signed [COORD_BITS-1:0] q0,
                                         input logic signed [COORD_BITS-1:0] q1,
                                         output logic [ADDR_BITS-1:0] leaf);
        int     d;
        longint lim;
        longint cur;
        longint off;
        longint child;
        int     lv;
        int     idx;
        d = int'(dim_reg);
        if (d < 1)
        begin
            d = 1;
        end
        if (d > 2)
        begin
            d = 2;
        end
        lim = quads_through(d, int'(level_reg));
        if (lim > TABLE_DEPTH)
        begin
            lim = TABLE_DEPTH;
        end
        cur  = 0;
        off  = 0;
        lv   = 0;
        leaf = '0;
        while (1'b1)
        begin
            if (!split_written[cur])
            begin
                return int'(cur);
            end
            idx = 0;
            if (q0 >= split_x[cur])
            begin
                idx = idx | 1;
            end
            if (d == 2 && q1 >= split_y[cur])
            begin
                idx = idx | 2;
            end
            child = quads_through(d, lv) + (off << d) + idx;
            if (child >= lim)
            begin
                break;
            end
            off = (off << d) + idx;
            lv  = lv + 1;
            cur = child;
        end
        leaf = cur[ADDR_BITS-1:0];
        return -1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic stim_row_t reg_row(input reg_idx_t r, input int v);
        stim_row_t row;
        row.kind  = ROW_REG;
        row.rsel  = r;
        row.value = PDATA_W'(v);
        row.op    = OP_WRITE;
        row.entry = '0;
        row.c0    = '0;
        row.c1    = '0;
        row.typed = 1'b0;
        row.quad  = '0;
        return row;
    endfunction

    function automatic stim_row_t wr_row(input int e, input logic signed [COORD_BITS-1:0] x,
                                         input logic signed [COORD_BITS-1:0] y);
        stim_row_t row;
        row.kind  = ROW_WORD;
        row.rsel  = REG_DIM_COUNT;
        row.value = '0;
        row.op    = OP_WRITE;
        row.entry = ADDR_BITS'(e);
        row.c0    = x;
        row.c1    = y;
        row.typed = 1'b0;
        row.quad  = '0;
        return row;
    endfunction

    function automatic stim_row_t loc_row(input logic signed [COORD_BITS-1:0] x,
                                          input logic signed [COORD_BITS-1:0] y,
                                          input bit typed, input int q);
        stim_row_t row;
        row.kind  = ROW_WORD;
        row.rsel  = REG_DIM_COUNT;
        row.value = '0;
        row.op    = OP_LOCATE;
        row.entry = ADDR_BITS'($urandom);
        row.c0    = x;
        row.c1    = y;
        row.typed = typed;
        row.quad  = ADDR_BITS'(q);
        return row;
    endfunction

    // Split coordinate: mostly anything, sometimes an extreme.
    function automatic logic signed [COORD_BITS-1:0] pick_split();
        case ($urandom_range(0, 9))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return '0;
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    // Query coordinate: random, an extreme, or on / beside a stored split point so
    // the greater-or-equal boundary is hit often.
    function automatic logic signed [COORD_BITS-1:0] pick_coord(input bit second);
        int e;
        int r;
        r = $urandom_range(0, 15);
        if (r < 6 || written_list.size() == 0)
        begin
            return COORD_BITS'($urandom);
        end
        if (r < 8)
        begin
            case ($urandom_range(0, 3))
                0:       return C_MAX;
                1:       return C_MIN;
                2:       return '0;
                default: return -1;
            endcase
        end
        e = written_list[$urandom_range(0, written_list.size() - 1)];
        if (second)
        begin
            return split_y[e] + (int'($urandom_range(0, 2)) - 1);
        end
        return split_x[e] + (int'($urandom_range(0, 2)) - 1);
    endfunction

    // Offers one command word and waits until it is taken. start is left high so a
    // following word can go out back to back; callers lower it when they pause.
    task automatic send_word(input op_t op, input logic [ADDR_BITS-1:0] e,
                             input logic signed [COORD_BITS-1:0] x,
                             input logic signed [COORD_BITS-1:0] y,
                             input bit typed, input logic [ADDR_BITS-1:0] q);
        int                    gap;
        logic [ADDR_BITS-1:0]  leaf;
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 19);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start       <= 1'b1;
        opcode      <= op;
        entry_index <= e;
        coord_0     <= x;
        coord_1     <= y;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        n_words++;
        if (op == OP_WRITE)
        begin
            n_tab_writes++;
            if (!split_written[e])
            begin
                written_list.push_back(int'(e));
            end
            split_written[e] = 1'b1;
            split_x[e]       = x;
            split_y[e]       = y;
        end
        else
        begin
            n_locates++;
            if (typed)
            begin
                quadrant_due.push_back(q);
            end
            else
            begin
                void'(trace_descent(x, y, leaf));
                quadrant_due.push_back(leaf);
            end
        end
    endtask

    // A locate may only walk through written entries: any hole on its path is
    // filled with a random split point first, then the locate word goes out.
    task automatic issue_locate(input logic signed [COORD_BITS-1:0] x,
                                input logic signed [COORD_BITS-1:0] y,
                                input bit typed, input logic [ADDR_BITS-1:0] q);
        int                    hole;
        logic [ADDR_BITS-1:0]  leaf;
        hole = trace_descent(x, y, leaf);
        while (hole >= 0)
        begin
            send_word(OP_WRITE, ADDR_BITS'(hole), pick_split(), pick_split(), 1'b0, '0);
            hole = trace_descent(x, y, leaf);
        end
        send_word(OP_LOCATE, ADDR_BITS'($urandom), x, y, typed, q);
    endtask

    // Register write over APB, only once the pipeline has drained.
    task automatic program_register(input reg_idx_t r, input logic [PDATA_W-1:0] v);
        logic [PDATA_W-1:0] mask;
        mask = (r == REG_DIM_COUNT) ? PDATA_W'(3) : PDATA_W'(15);
        @(negedge clk);
        start <= 1'b0;
        while (quadrant_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({r, 2'b00});
        // upper data bits carry noise; the register keeps only its own field
        pwdata  <= (v & mask) | (PDATA_W'($urandom) & ~mask);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (r == REG_DIM_COUNT)
        begin
            dim_reg = v[DIM_W-1:0];
        end
        else
        begin
            level_reg = v[LEVEL_W-1:0];
        end
        n_settings++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic report_fault(input string msg);
        n_faults++;
        if (n_faults <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: one strobe, one word, compared with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [ADDR_BITS-1:0] want;
        if (rst_n && strobe)
        begin
            if (quadrant_due.size() == 0)
            begin
                report_fault($sformatf("unexpected result word: quadrant %0d at cycle %0d",
                                       quadrant, cycle_count));
            end
            else
            begin
                want = quadrant_due.pop_front();
                n_checked++;
                if (quadrant !== want)
                begin
                    report_fault($sformatf("quadrant mismatch at cycle %0d: expected %0d, got %0d",
                                           cycle_count, want, quadrant));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, quadrant_due.size());
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int dims   [4];
        int levels [4];
        int r;
        int phase_end;

        // Directed table. Entries 0..4 get split (0,0) so the one-level answers
        // can be worked out by hand; deeper rows rely on the predictor.
        stim_rows = '{
            wr_row(0, 0, 0), wr_row(1, 0, 0), wr_row(2, 0, 0),
            wr_row(3, 0, 0), wr_row(4, 0, 0),
            wr_row(TABLE_DEPTH - 1, C_MAX, C_MIN),          // top entry number
            // level 0: the root is the only quadrant
            reg_row(REG_LEVEL_COUNT, 0),
            loc_row(C_MAX, C_MAX, 1'b1, 0),
            loc_row(C_MIN, C_MIN, 1'b1, 0),
            // one dimension, one level: quadrant 1 below the split, 2 at or above
            reg_row(REG_DIM_COUNT, 1),
            reg_row(REG_LEVEL_COUNT, 1),
            loc_row(0, C_MIN, 1'b1, 2),                      // equal counts as above
            loc_row(-1, C_MAX, 1'b1, 1),
            loc_row(C_MAX, 0, 1'b1, 2),
            loc_row(C_MIN, C_MAX, 1'b1, 1),
            // two dimensions, one level: quadrant 1 + child index
            reg_row(REG_DIM_COUNT, 2),
            loc_row(C_MAX, C_MIN, 1'b1, 2),
            loc_row(C_MIN, C_MAX, 1'b1, 3),
            loc_row(0, 0, 1'b1, 4),
            loc_row(C_MIN, C_MIN, 1'b1, 1),
            // zero dimensions behaves as one
            reg_row(REG_DIM_COUNT, 0),
            loc_row(5, C_MAX, 1'b1, 2),
            loc_row(-5, C_MAX, 1'b1, 1),
            // three dimensions saturates to two
            reg_row(REG_DIM_COUNT, 3),
            loc_row(C_MAX, C_MAX, 1'b1, 4),
            // deep settings: descent bounded by the table depth
            reg_row(REG_LEVEL_COUNT, 15),
            reg_row(REG_DIM_COUNT, 1),
            loc_row(C_MAX, C_MIN, 1'b0, 0),
            loc_row(C_MIN, C_MAX, 1'b0, 0),
            reg_row(REG_LEVEL_COUNT, 10),
            loc_row(0, 0, 1'b0, 0),
            reg_row(REG_DIM_COUNT, 2),
            loc_row(C_MAX, C_MAX, 1'b0, 0),
            loc_row(C_MIN, 0, 1'b0, 0)
        };

        // first four phases use fixed settings, extremes among them; the rest pick at random
        dims   = '{2, 1, 3, 0};
        levels = '{15, 10, 0, 15};

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_REG)
            begin
                program_register(stim_rows[i].rsel, stim_rows[i].value);
            end
            else if (stim_rows[i].op == OP_WRITE)
            begin
                send_word(OP_WRITE, stim_rows[i].entry, stim_rows[i].c0, stim_rows[i].c1,
                          1'b0, '0);
            end
            else
            begin
                issue_locate(stim_rows[i].c0, stim_rows[i].c1, stim_rows[i].typed,
                             stim_rows[i].quad);
            end
        end

        // Random phases: mostly locates (with holes on their path filled first),
        // the rest rewrites of arbitrary entries. No gaps in the closing phase.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 4)
            begin
                program_register(REG_DIM_COUNT, PDATA_W'(dims[ph]));
                program_register(REG_LEVEL_COUNT, PDATA_W'(levels[ph]));
            end
            else
            begin
                program_register(REG_DIM_COUNT, PDATA_W'($urandom_range(0, 3)));
                program_register(REG_LEVEL_COUNT, PDATA_W'($urandom_range(0, 15)));
            end
            gaps_on   = (ph != PHASES - 1);
            phase_end = n_words + PHASE_WORDS;
            while (n_words < phase_end)
            begin
                if (ph != PHASES - 1 && $urandom_range(0, 39) == 0)
                begin
                    gaps_on = !gaps_on;
                end
                r = $urandom_range(0, 9);
                if (r < 2)
                begin
                    send_word(OP_WRITE, ADDR_BITS'($urandom), pick_split(), pick_split(),
                              1'b0, '0);
                end
                else
                begin
                    issue_locate(pick_coord(1'b0), pick_coord(1'b1), 1'b0, '0);
                end
            end
        end

        // drain: every result in, then wait out SETTLE
        @(negedge clk);
        start <= 1'b0;
        while (quadrant_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
        if (quadrant_due.size() != 0)
        begin
            report_fault($sformatf("%0d expected results never arrived", quadrant_due.size()));
        end

        $display("%0d command words (%0d locates, %0d table writes), %0d register writes",
                 n_words, n_locates, n_tab_writes, n_settings);
        $display("%0d results checked, %0d mismatches, %0d cycles",
                 n_checked, n_faults, cycle_count);
        if (n_faults == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/hql_pkg.sv
rtl/hql_ram.sv
rtl/hql_level.sv
rtl/hierarchical_quadrant_locator.sv
rtl/hql_checker.sv
tb/sv/hierarchical_quadrant_locator_tb.sv
